### hw/rtl/pfld_pkg.sv
package pfld_pkg;

   localparam int COORD_W = 10;
   localparam int ERR_W = 13;
   localparam int IDX_W = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] OP_LINE = 2'd0;
   localparam logic [1:0] OP_FILL = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [7:0] BYTE_ONES = 8'hFF;
   localparam logic [7:0] BYTE_ZEROS = 8'h00;
   localparam logic [2:0] ROW_IN_PAGE_MASK = 3'h7;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ERR_W-1:0] err_type;

   typedef enum logic [1:0] {
      CMD_LINE,
      CMD_FILL,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic colour;
      coord_type x;
      coord_type y;
      coord_type xe;
      coord_type ye;
      err_type dx;
      err_type dy;
      err_type err;
      logic sx_neg;
      logic sy_neg;
      logic [COORD_W-1:0] addr;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LINE_PLOT,
      ST_LINE_WRITE,
      ST_FILL,
      ST_READ_WAIT,
      ST_RESPOND
   } back_state_type;

endpackage

### hw/rtl/pfld_ram.sv
module pfld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pfld_front.sv
module pfld_front (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_op,
   input  pfld_pkg::coord_type       req_x_start,
   input  pfld_pkg::coord_type       req_y_start,
   input  pfld_pkg::coord_type       req_x_end,
   input  pfld_pkg::coord_type       req_y_end,
   input  logic                      req_colour,
   input  logic [pfld_pkg::COORD_W-1:0] req_byte_addr,
   input  logic                      clearing,
   output logic                      push_valid,
   input  logic                      push_ready,
   output pfld_pkg::cmd_type         push_cmd
);

   pfld_pkg::err_type xs, ys, xe, ye, dx, dy_abs;
   logic known_op;

   always_comb begin
      xs = pfld_pkg::ERR_W'(req_x_start);
      ys = pfld_pkg::ERR_W'(req_y_start);
      xe = pfld_pkg::ERR_W'(req_x_end);
      ye = pfld_pkg::ERR_W'(req_y_end);
      dx = (xe >= xs) ? (xe - xs) : (xs - xe);
      dy_abs = (ye >= ys) ? (ye - ys) : (ys - ye);

      push_cmd.colour = req_colour;
      push_cmd.x = req_x_start;
      push_cmd.y = req_y_start;
      push_cmd.xe = req_x_end;
      push_cmd.ye = req_y_end;
      push_cmd.dx = dx;
      push_cmd.dy = -dy_abs;
      push_cmd.err = dx - dy_abs;
      push_cmd.sx_neg = !(xs < xe);
      push_cmd.sy_neg = !(ys < ye);
      push_cmd.addr = req_byte_addr;

      known_op = 1'b1;
      unique case (req_op)
         pfld_pkg::OP_LINE: push_cmd.kind = pfld_pkg::CMD_LINE;
         pfld_pkg::OP_FILL: push_cmd.kind = pfld_pkg::CMD_FILL;
         pfld_pkg::OP_READ: push_cmd.kind = pfld_pkg::CMD_READ;
         default: begin
            push_cmd.kind = pfld_pkg::CMD_LINE;
            known_op = 1'b0;
         end
      endcase
   end

   assign req_ready = push_ready && !clearing;
   assign push_valid = req_valid && !clearing && known_op;

endmodule

### hw/rtl/pfld_queue.sv
module pfld_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  pfld_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output pfld_pkg::cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(pfld_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(pfld_pkg::QUEUE_DEPTH + 1);

   pfld_pkg::cmd_type entry_ff [pfld_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(pfld_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(pfld_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(pfld_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/pfld_back.sv
module pfld_back #(
   parameter int DISPLAY_WIDTH = 128,
   parameter int DISPLAY_HEIGHT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  pfld_pkg::cmd_type pop_cmd,
   output logic              clearing,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_read_data
);

   localparam int PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
   localparam int AW = $clog2(STORE_BYTES);
   localparam int IW = pfld_pkg::IDX_W;

   pfld_pkg::back_state_type state_ff, state_in;
   pfld_pkg::coord_type x_ff, x_in, y_ff, y_in, xe_ff, xe_in, ye_ff, ye_in;
   pfld_pkg::err_type dx_ff, dx_in, dy_ff, dy_in, err_ff, err_in;
   logic sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in, colour_ff, colour_in;
   logic [AW-1:0] count_ff, count_in;
   logic [7:0] data_ff, data_in;

   logic wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0] wr_data, rd_data;

   logic in_bounds, at_end, step_x, step_y;
   logic [IW-1:0] pixel_idx_full, read_idx_full;
   logic [7:0] mask;
   logic signed [pfld_pkg::ERR_W:0] e2;
   pfld_pkg::coord_type x_next, y_next;
   pfld_pkg::err_type err_next;

   pfld_ram #(
      .WIDTH(8),
      .DEPTH(STORE_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      in_bounds = !x_ff[pfld_pkg::COORD_W-1] && !y_ff[pfld_pkg::COORD_W-1]
         && ({2'b00, x_ff[8:0]} < 11'(DISPLAY_WIDTH))
         && ({2'b00, y_ff[8:0]} < 11'(DISPLAY_HEIGHT));
      pixel_idx_full = IW'(DISPLAY_WIDTH) * IW'(y_ff[8:3]) + IW'(x_ff[8:0]);
      read_idx_full = IW'(pop_cmd.addr);
      mask = 8'(1) << (y_ff[2:0] & pfld_pkg::ROW_IN_PAGE_MASK);
      at_end = (x_ff == xe_ff) && (y_ff == ye_ff);
      e2 = {err_ff, 1'b0};
      step_x = e2 >= (pfld_pkg::ERR_W + 1)'(dy_ff);
      step_y = e2 <= (pfld_pkg::ERR_W + 1)'(dx_ff);
      x_next = step_x ? (sx_neg_ff ? x_ff - 1'b1 : x_ff + 1'b1) : x_ff;
      y_next = step_y ? (sy_neg_ff ? y_ff - 1'b1 : y_ff + 1'b1) : y_ff;
      err_next = err_ff + (step_x ? dy_ff : '0) + (step_y ? dx_ff : '0);
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;
      y_in = y_ff;
      xe_in = xe_ff;
      ye_in = ye_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      err_in = err_ff;
      sx_neg_in = sx_neg_ff;
      sy_neg_in = sy_neg_ff;
      colour_in = colour_ff;
      count_in = count_ff;
      data_in = data_ff;
      wr_en = 1'b0;
      wr_addr = pixel_idx_full[AW-1:0];
      wr_data = pfld_pkg::BYTE_ZEROS;
      rd_en = 1'b0;
      rd_addr = pixel_idx_full[AW-1:0];
      pop_ready = 1'b0;
      rsp_valid = 1'b0;
      clearing = 1'b0;

      unique case (state_ff)
         pfld_pkg::ST_CLEAR: begin
            clearing = 1'b1;
            wr_en = 1'b1;
            wr_addr = count_ff;
            wr_data = pfld_pkg::BYTE_ZEROS;
            count_in = count_ff + 1'b1;
            if (count_ff == AW'(STORE_BYTES - 1)) begin
               state_in = pfld_pkg::ST_IDLE;
            end
         end
         pfld_pkg::ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               x_in = pop_cmd.x;
               y_in = pop_cmd.y;
               xe_in = pop_cmd.xe;
               ye_in = pop_cmd.ye;
               dx_in = pop_cmd.dx;
               dy_in = pop_cmd.dy;
               err_in = pop_cmd.err;
               sx_neg_in = pop_cmd.sx_neg;
               sy_neg_in = pop_cmd.sy_neg;
               colour_in = pop_cmd.colour;
               count_in = '0;
               unique case (pop_cmd.kind)
                  pfld_pkg::CMD_LINE: state_in = pfld_pkg::ST_LINE_PLOT;
                  pfld_pkg::CMD_FILL: state_in = pfld_pkg::ST_FILL;
                  pfld_pkg::CMD_READ: begin
                     if (read_idx_full < IW'(STORE_BYTES)) begin
                        rd_en = 1'b1;
                        rd_addr = read_idx_full[AW-1:0];
                        state_in = pfld_pkg::ST_READ_WAIT;
                     end else begin
                        data_in = pfld_pkg::BYTE_ZEROS;
                        state_in = pfld_pkg::ST_RESPOND;
                     end
                  end
                  default: state_in = pfld_pkg::ST_IDLE;
               endcase
            end
         end
         pfld_pkg::ST_LINE_PLOT: begin
            if (in_bounds) begin
               rd_en = 1'b1;
               state_in = pfld_pkg::ST_LINE_WRITE;
            end else if (at_end) begin
               state_in = pfld_pkg::ST_IDLE;
            end else begin
               x_in = x_next;
               y_in = y_next;
               err_in = err_next;
            end
         end
         pfld_pkg::ST_LINE_WRITE: begin
            wr_en = 1'b1;
            wr_data = colour_ff ? (rd_data | mask) : (rd_data & ~mask);
            if (at_end) begin
               state_in = pfld_pkg::ST_IDLE;
            end else begin
               x_in = x_next;
               y_in = y_next;
               err_in = err_next;
               state_in = pfld_pkg::ST_LINE_PLOT;
            end
         end
         pfld_pkg::ST_FILL: begin
            wr_en = 1'b1;
            wr_addr = count_ff;
            wr_data = colour_ff ? pfld_pkg::BYTE_ONES : pfld_pkg::BYTE_ZEROS;
            count_in = count_ff + 1'b1;
            if (count_ff == AW'(STORE_BYTES - 1)) begin
               state_in = pfld_pkg::ST_IDLE;
            end
         end
         pfld_pkg::ST_READ_WAIT: begin
            data_in = rd_data;
            state_in = pfld_pkg::ST_RESPOND;
         end
         pfld_pkg::ST_RESPOND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = pfld_pkg::ST_IDLE;
            end
         end
         default: state_in = pfld_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfld_pkg::ST_CLEAR;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      xe_ff <= xe_in;
      ye_ff <= ye_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      err_ff <= err_in;
      sx_neg_ff <= sx_neg_in;
      sy_neg_ff <= sy_neg_in;
      colour_ff <= colour_in;
      data_ff <= data_in;
   end

   assign rsp_read_data = data_ff;

endmodule

### hw/rtl/paged_framebuffer_line_draw_unit.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  op, x/y start, x/y end, colour, byte_addr
// rsp       out        rsp_valid / rsp_ready  read_data (one per read item)
//
// Line: per on-screen pixel a store read then a write, per off-screen pixel a step only.
// Fill: one store write per byte over DISPLAY_WIDTH*ceil(DISPLAY_HEIGHT/8) bytes. Read:
// the store read is issued as the item is taken, the byte is registered, then rsp_valid
// rises; an address past the store reads 0. Reset starts a clearing pass that zeroes all
// store bytes (1024 by default) with req_ready low. A two-item queue takes items while the
// back end works or waits on rsp_ready; req_ready drops while the queue is full.
module paged_framebuffer_line_draw_unit #(
   parameter int DISPLAY_WIDTH = 128,
   parameter int DISPLAY_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic signed [9:0] req_x_start,
   input  logic signed [9:0] req_y_start,
   input  logic signed [9:0] req_x_end,
   input  logic signed [9:0] req_y_end,
   input  logic        req_colour,
   input  logic [9:0]  req_byte_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data
);

   logic clearing;
   logic push_valid, push_ready, pop_valid, pop_ready;
   pfld_pkg::cmd_type push_cmd, pop_cmd;

   pfld_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_x_start  (req_x_start),
      .req_y_start  (req_y_start),
      .req_x_end    (req_x_end),
      .req_y_end    (req_y_end),
      .req_colour   (req_colour),
      .req_byte_addr(req_byte_addr),
      .clearing     (clearing),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_cmd     (push_cmd)
   );

   pfld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd  (push_cmd),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd)
   );

   pfld_back #(
      .DISPLAY_WIDTH (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_cmd      (pop_cmd),
      .clearing     (clearing),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_read_data(rsp_read_data)
   );

endmodule
